[rtl/block_linear_resampler_assert.svh]
// assertion macros for the block linear resampler
`ifndef BLOCK_LINEAR_RESAMPLER_ASSERT_SVH
`define BLOCK_LINEAR_RESAMPLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/blr_pkg.sv]
// shared constants for the block linear resampler
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int BLOCK_CFG_W = 13;
    localparam int STEP_W      = 20;
    localparam int MODE_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_PER_BLOCK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_PER_BLOCK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP          = 2'd3;

    localparam logic [MODE_W-1:0] MODE_LINEAR     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO_STUFF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD       = 2'd2;
    // spare code, handled as sample hold
    localparam logic [MODE_W-1:0] MODE_SPARE      = 2'd3;

    localparam logic [MODE_W-1:0]      MODE_RESET  = MODE_LINEAR;
    localparam logic [BLOCK_CFG_W-1:0] BLOCK_RESET = 13'd1024;
    localparam logic [STEP_W-1:0]      STEP_RESET  = 20'd65536;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

endpackage

`default_nettype wire

[rtl/block_linear_resampler.sv]
// Block linear resampler. Each accepted input sample word yields zero to eight output
// words on the result channel, one per clock unless m_tready stalls it, through a single
// interpolation unit (one multiply and round per output) feeding the output register.
// An input word holds the unit until its outputs, at most eight, are loaded; the next
// input word is taken in the cycle its last output is loaded, so the result channel can
// run at one word per clock when it is never stalled. Configuration writes take effect
// at once and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

`include "block_linear_resampler_assert.svh"

module block_linear_resampler #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 16,
    parameter int MAX_BLOCK    = 4096
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // sample_in
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // sample_out
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_tdata,
    // last_of_run
    output logic                                      m_tlast,

    input  wire logic                                 cfg_we,
    input  wire logic [blr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [blr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDX_W   = $clog2(MAX_BLOCK);
    localparam int BLK_W   = IDX_W + 1;
    localparam int POS_W   = IDX_W + FRAC_BITS;
    localparam int SUM_W   = ((POS_W > blr_pkg::STEP_W) ? POS_W : blr_pkg::STEP_W) + 1;
    localparam int PROD_W  = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam int CNT_W   = blr_pkg::CNT_W;

    localparam logic [POS_W-1:0] POS_MAX =
        POS_W'((64'(MAX_BLOCK) << FRAC_BITS) - 64'd1);
    localparam logic [FRAC_BITS-1:0] SNAP_FR =
        FRAC_BITS'(((64'd99993 << FRAC_BITS) + 64'd99999) / 64'd100000);
    localparam logic [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(blr_pkg::MAX_RESULTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(blr_pkg::MAX_RESULTS - 1);

    function automatic logic [BLK_W-1:0] clamp_blk(input logic [blr_pkg::BLOCK_CFG_W-1:0] v);
        logic [BLK_W-1:0] r;
        if (v == '0) begin
            r = BLK_W'(1);
        end else if (32'(v) > 32'(MAX_BLOCK)) begin
            r = BLK_W'(MAX_BLOCK);
        end else begin
            r = BLK_W'(v);
        end
        return r;
    endfunction

    // configuration
    logic [blr_pkg::MODE_W-1:0]      mode_reg;
    logic [blr_pkg::BLOCK_CFG_W-1:0] ipb_cfg_reg;
    logic [blr_pkg::BLOCK_CFG_W-1:0] opb_cfg_reg;
    logic [blr_pkg::STEP_W-1:0]      step_reg;

    // block state
    logic signed [SAMPLE_WIDTH-1:0]  prev_reg;
    logic [IDX_W-1:0]                in_idx_reg;
    logic [BLK_W-1:0]                out_idx_reg;
    logic [POS_W-1:0]                pos_reg;
    logic [BLK_W-1:0]                zs_pos_reg;
    logic                            zs_valid_reg;

    // input word and output word
    logic                            busy_reg;
    logic signed [SAMPLE_WIDTH-1:0]  cur_reg;
    logic [CNT_W-1:0]                count_reg;
    logic                            m_tvalid_reg;
    logic [SAMPLE_WIDTH-1:0]         out_sample_reg;
    logic                            out_last_reg;

    logic [BLK_W-1:0]                ipb;
    logic [BLK_W-1:0]                opb;
    logic [BLK_W-1:0]                n_ext;
    logic                            block_end;
    logic                            snap;
    logic [BLK_W-1:0]                ip;
    logic [FRAC_BITS-1:0]            fr;
    logic [SUM_W-1:0]                pos_sum;
    logic [POS_W-1:0]                pos_next;
    logic                            snap_n;
    logic [BLK_W-1:0]                ip_n;
    logic                            emit;
    logic                            emit_last;
    logic                            out_free;
    logic                            step_go;
    logic                            item_done;
    logic                            in_fire;
    logic                            zs_hit;
    logic signed [SAMPLE_WIDTH:0]    diff;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        shifted;
    logic [SAMPLE_WIDTH-1:0]         val;

    always_comb begin
        ipb   = clamp_blk(ipb_cfg_reg);
        opb   = clamp_blk(opb_cfg_reg);
        n_ext = {1'b0, in_idx_reg};
        block_end = (n_ext + BLK_W'(1)) >= ipb;

        snap = pos_reg[FRAC_BITS-1:0] >= SNAP_FR;
        ip   = {1'b0, pos_reg[POS_W-1:FRAC_BITS]} + BLK_W'(snap);
        fr   = snap ? '0 : pos_reg[FRAC_BITS-1:0];

        pos_sum  = SUM_W'(pos_reg) + SUM_W'(step_reg);
        pos_next = (pos_sum > SUM_W'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];
        snap_n   = pos_next[FRAC_BITS-1:0] >= SNAP_FR;
        ip_n     = {1'b0, pos_next[POS_W-1:FRAC_BITS]} + BLK_W'(snap_n);

        emit = busy_reg && (count_reg < CNT_MAX) && (out_idx_reg < opb)
               && (block_end || (ip <= n_ext));
        emit_last = !((count_reg != CNT_LAST) && ((out_idx_reg + BLK_W'(1)) < opb)
                      && (block_end || (ip_n <= n_ext)));

        out_free  = !m_tvalid_reg || m_tready;
        step_go   = busy_reg && (!emit || out_free);
        item_done = step_go && (!emit || emit_last);
        s_tready  = !busy_reg || item_done;
        in_fire   = s_tvalid && s_tready;
    end

    // interpolation and output selection
    always_comb begin
        diff    = (SAMPLE_WIDTH+1)'(cur_reg) - (SAMPLE_WIDTH+1)'(prev_reg);
        prod    = diff * $signed({1'b0, fr});
        shifted = (prod + $signed(HALF)) >>> FRAC_BITS;
        zs_hit  = zs_valid_reg && (zs_pos_reg == ip);
        unique case (mode_reg)
            blr_pkg::MODE_LINEAR: begin
                val = prev_reg + shifted[SAMPLE_WIDTH-1:0];
            end
            blr_pkg::MODE_ZERO_STUFF: begin
                val = zs_hit ? '0 : cur_reg;
            end
            default: begin
                val = cur_reg;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= blr_pkg::MODE_RESET;
            ipb_cfg_reg <= blr_pkg::BLOCK_RESET;
            opb_cfg_reg <= blr_pkg::BLOCK_RESET;
            step_reg    <= blr_pkg::STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                blr_pkg::REG_MODE:          mode_reg    <= cfg_wdata[blr_pkg::MODE_W-1:0];
                blr_pkg::REG_IN_PER_BLOCK:  ipb_cfg_reg <= cfg_wdata[blr_pkg::BLOCK_CFG_W-1:0];
                blr_pkg::REG_OUT_PER_BLOCK: opb_cfg_reg <= cfg_wdata[blr_pkg::BLOCK_CFG_W-1:0];
                blr_pkg::REG_STEP:          step_reg    <= cfg_wdata[blr_pkg::STEP_W-1:0];
            endcase
        end
    end

    // control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            prev_reg     <= '0;
            in_idx_reg   <= '0;
            out_idx_reg  <= '0;
            pos_reg      <= '0;
            zs_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (item_done) begin
                busy_reg <= 1'b0;
            end
            if (step_go && emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (item_done) begin
                prev_reg  <= cur_reg;
                count_reg <= '0;
                if (block_end) begin
                    in_idx_reg   <= '0;
                    out_idx_reg  <= '0;
                    pos_reg      <= '0;
                    zs_valid_reg <= 1'b0;
                end else begin
                    in_idx_reg <= in_idx_reg + IDX_W'(1);
                    if (emit) begin
                        out_idx_reg <= out_idx_reg + BLK_W'(1);
                        pos_reg     <= pos_next;
                        if (mode_reg == blr_pkg::MODE_ZERO_STUFF && !zs_hit) begin
                            zs_valid_reg <= 1'b1;
                        end
                    end
                end
            end else if (step_go && emit) begin
                count_reg   <= count_reg + CNT_W'(1);
                out_idx_reg <= out_idx_reg + BLK_W'(1);
                pos_reg     <= pos_next;
                if (mode_reg == blr_pkg::MODE_ZERO_STUFF && !zs_hit) begin
                    zs_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cur_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (step_go && emit) begin
            out_sample_reg <= val;
            out_last_reg   <= emit_last;
            if (mode_reg == blr_pkg::MODE_ZERO_STUFF && !zs_hit) begin
                zs_pos_reg <= ip;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_sample_reg);
    assign m_tlast  = out_last_reg;

    `BLR_ASSERT_NOW(a_pos_in_range, 1'b1, pos_reg <= POS_MAX, "position above limit")
    `BLR_ASSERT_NOW(a_count_needs_word, count_reg != '0, busy_reg, "count without word")
    `BLR_ASSERT_NEXT(a_last_ends_run, step_go && emit && emit_last, count_reg == '0,
        "run continues after last")
    `BLR_ASSERT_NEXT(a_block_restart, item_done && block_end,
        in_idx_reg == '0 && pos_reg == '0 && out_idx_reg == '0, "block state not cleared")

endmodule

`default_nettype wire
